// ===== hdl/pcm_minmax_envelope_binner_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PCM_MINMAX_ENVELOPE_BINNER_CORE_DEFINES_SVH
`define PCM_MINMAX_ENVELOPE_BINNER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define PMEB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define PMEB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pmeb_pkg.sv =====
package pmeb_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int MAX_BINS     = 1024;

    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 19;
    localparam int TOTAL_W   = 31;
    localparam int BINS_W    = 11;
    localparam int CHANS_W   = 4;
    localparam int BIN_IDX_W = 10;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(2);

    localparam logic [TOTAL_W-1:0] TOTAL_FRAMES_RST  = '0;
    localparam logic [BINS_W-1:0]  BIN_COUNT_RST     = BINS_W'(1024);
    localparam logic [CHANS_W-1:0] CHANNEL_COUNT_RST = CHANS_W'(2);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_ACC,
        CMD_CLOSE,
        CMD_ERR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                  kind;
        logic [BIN_IDX_W-1:0]       bin_idx;
        logic signed [SUM_W-1:0]    sum;
    } t_bin_cmd;

endpackage

// ===== hdl/pmeb_if.sv =====
interface pmeb_in_if import pmeb_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_ch0;
    logic signed [SAMPLE_W-1:0] sample_ch1;
    logic signed [SAMPLE_W-1:0] sample_ch2;
    logic signed [SAMPLE_W-1:0] sample_ch3;
    logic signed [SAMPLE_W-1:0] sample_ch4;
    logic signed [SAMPLE_W-1:0] sample_ch5;
    logic signed [SAMPLE_W-1:0] sample_ch6;
    logic signed [SAMPLE_W-1:0] sample_ch7;

    modport source (
        output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
               sample_ch4, sample_ch5, sample_ch6, sample_ch7,
        input  ready
    );
    modport sink (
        input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
               sample_ch4, sample_ch5, sample_ch6, sample_ch7,
        output ready
    );
endinterface

interface pmeb_out_if import pmeb_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [BIN_IDX_W-1:0]        bin_number;
    logic signed [SUM_W-1:0]     bin_low;
    logic signed [SUM_W-1:0]     bin_high;
    logic                        config_error;

    modport source (
        output valid, bin_number, bin_low, bin_high, config_error,
        input  ready
    );
    modport sink (
        input  valid, bin_number, bin_low, bin_high, config_error,
        output ready
    );
endinterface

interface pmeb_cfg_if import pmeb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] write_data;

    modport source (
        output valid, reg_index, write_data,
        input  ready
    );
    modport sink (
        input  valid, reg_index, write_data,
        output ready
    );
endinterface

// ===== hdl/pmeb_front.sv =====
module pmeb_front import pmeb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pmeb_in_if.sink     i_frame,
    pmeb_cfg_if.sink    i_cfg,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_bin_cmd    o_q_cmd,
    output logic        o_restart
);

    logic [TOTAL_W-1:0]   r_total, n_total;
    logic [BINS_W-1:0]    r_bins, n_bins;
    logic [CHANS_W-1:0]   r_chans, n_chans;
    logic [TOTAL_W-1:0]   r_frames, n_frames;
    logic [BIN_IDX_W-1:0] r_bin, n_bin;
    // slack = (bin+1)*T - (frames+1)*B, kept in [0, T)
    logic [TOTAL_W-1:0]   r_slack, n_slack;

    logic                       w_take;
    logic                       w_cfg_hit;
    logic                       w_bad;
    logic                       w_done;
    logic                       w_close;
    logic [TOTAL_W-1:0]         w_bins_ext;
    logic [CHANS_W-1:0]         w_nch;
    logic signed [SAMPLE_W-1:0] w_smp [MAX_CHANNELS];
    logic signed [SUM_W-1:0]    w_sum;

    assign i_frame.ready = !i_q_full;
    assign i_cfg.ready   = 1'b1;
    assign w_take        = i_frame.valid && i_frame.ready;

    assign w_smp[0] = i_frame.sample_ch0;
    assign w_smp[1] = i_frame.sample_ch1;
    assign w_smp[2] = i_frame.sample_ch2;
    assign w_smp[3] = i_frame.sample_ch3;
    assign w_smp[4] = i_frame.sample_ch4;
    assign w_smp[5] = i_frame.sample_ch5;
    assign w_smp[6] = i_frame.sample_ch6;
    assign w_smp[7] = i_frame.sample_ch7;

    assign w_bins_ext = TOTAL_W'(r_bins);
    assign w_bad  = (r_bins == '0) || (32'(r_bins) > 32'(MAX_BINS)) || (r_total < w_bins_ext);
    assign w_done = r_frames >= r_total;
    assign w_close = w_bins_ext > r_slack;

    always_comb begin
        if (r_chans == '0) begin
            w_nch = CHANS_W'(1);
        end else if (32'(r_chans) > 32'(MAX_CHANNELS)) begin
            w_nch = CHANS_W'(MAX_CHANNELS);
        end else begin
            w_nch = r_chans;
        end
    end

    always_comb begin
        w_sum = '0;
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            if (CHANS_W'(c) < w_nch) begin
                w_sum = w_sum + SUM_W'(w_smp[c]);
            end
        end
    end

    always_comb begin
        n_total   = r_total;
        n_bins    = r_bins;
        n_chans   = r_chans;
        n_frames  = r_frames;
        n_bin     = r_bin;
        n_slack   = r_slack;
        w_cfg_hit = 1'b0;
        o_q_push  = 1'b0;
        o_q_cmd.kind    = CMD_ACC;
        o_q_cmd.bin_idx = r_bin;
        o_q_cmd.sum     = w_sum;

        if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                REG_TOTAL_FRAMES: begin
                    n_total   = i_cfg.write_data[TOTAL_W-1:0];
                    w_cfg_hit = 1'b1;
                end
                REG_BIN_COUNT: begin
                    n_bins    = i_cfg.write_data[BINS_W-1:0];
                    w_cfg_hit = 1'b1;
                end
                REG_CHANNEL_COUNT: begin
                    n_chans   = i_cfg.write_data[CHANS_W-1:0];
                    w_cfg_hit = 1'b1;
                end
                default: begin
                    w_cfg_hit = 1'b0;
                end
            endcase
        end

        if (w_cfg_hit) begin
            n_frames = '0;
            n_bin    = '0;
            n_slack  = n_total - TOTAL_W'(n_bins);
        end else if (w_take) begin
            if (w_bad) begin
                o_q_push     = 1'b1;
                o_q_cmd.kind = CMD_ERR;
            end else if (!w_done) begin
                o_q_push = 1'b1;
                n_frames = r_frames + TOTAL_W'(1);
                if (w_close) begin
                    o_q_cmd.kind = CMD_CLOSE;
                    n_bin        = r_bin + BIN_IDX_W'(1);
                    n_slack      = r_slack - w_bins_ext + r_total;
                end else begin
                    n_slack      = r_slack - w_bins_ext;
                end
            end
        end
    end

    assign o_restart = w_cfg_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= TOTAL_FRAMES_RST;
            r_bins   <= BIN_COUNT_RST;
            r_chans  <= CHANNEL_COUNT_RST;
            r_frames <= '0;
            r_bin    <= '0;
            r_slack  <= '0;
        end else begin
            r_total  <= n_total;
            r_bins   <= n_bins;
            r_chans  <= n_chans;
            r_frames <= n_frames;
            r_bin    <= n_bin;
            r_slack  <= n_slack;
        end
    end

endmodule

// ===== hdl/pmeb_cmd_fifo.sv =====
module pmeb_cmd_fifo import pmeb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_bin_cmd i_cmd,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_valid,
    output t_bin_cmd o_cmd
);

    t_bin_cmd              r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count, n_count;

    assign o_full  = r_count == CMDQ_CNT_W'(CMDQ_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CMDQ_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CMDQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + CMDQ_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + CMDQ_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

// ===== hdl/pmeb_back.sv =====
module pmeb_back import pmeb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_bin_cmd    i_q_cmd,
    output logic        o_q_pop,
    input  logic        i_restart,
    pmeb_out_if.source  o_bin
);

    logic                    r_out_valid, n_out_valid;
    logic [BIN_IDX_W-1:0]    r_bin_number;
    logic signed [SUM_W-1:0] r_bin_low;
    logic signed [SUM_W-1:0] r_bin_high;
    logic                    r_config_error;
    logic signed [SUM_W-1:0] r_lo;
    logic signed [SUM_W-1:0] r_hi;

    logic signed [SUM_W-1:0] w_lo;
    logic signed [SUM_W-1:0] w_hi;

    assign o_q_pop = i_q_valid && (!r_out_valid || o_bin.ready);
    assign w_lo    = (i_q_cmd.sum < r_lo) ? i_q_cmd.sum : r_lo;
    assign w_hi    = (i_q_cmd.sum > r_hi) ? i_q_cmd.sum : r_hi;

    assign o_bin.valid        = r_out_valid;
    assign o_bin.bin_number   = r_bin_number;
    assign o_bin.bin_low      = r_bin_low;
    assign o_bin.bin_high     = r_bin_high;
    assign o_bin.config_error = r_config_error;

    always_comb begin
        n_out_valid = r_out_valid && !o_bin.ready;
        if (o_q_pop && !i_restart && (i_q_cmd.kind inside {CMD_CLOSE, CMD_ERR})) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_lo        <= SUM_MAX;
            r_hi        <= SUM_MIN;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_restart) begin
                r_lo <= SUM_MAX;
                r_hi <= SUM_MIN;
            end else if (o_q_pop) begin
                case (i_q_cmd.kind)
                    CMD_ACC: begin
                        r_lo <= w_lo;
                        r_hi <= w_hi;
                    end
                    CMD_CLOSE: begin
                        r_lo <= SUM_MAX;
                        r_hi <= SUM_MIN;
                    end
                    CMD_ERR: begin
                        r_lo <= r_lo;
                    end
                    default: begin
                        r_lo <= r_lo;
                    end
                endcase
            end
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            case (i_q_cmd.kind)
                CMD_CLOSE: begin
                    r_bin_number   <= i_q_cmd.bin_idx;
                    r_bin_low      <= w_lo;
                    r_bin_high     <= w_hi;
                    r_config_error <= 1'b0;
                end
                CMD_ERR: begin
                    r_bin_number   <= '0;
                    r_bin_low      <= '0;
                    r_bin_high     <= '0;
                    r_config_error <= 1'b1;
                end
                default: begin
                    r_bin_number   <= r_bin_number;
                end
            endcase
        end
    end

endmodule

// ===== hdl/pcm_minmax_envelope_binner_core.sv =====
// A frame beat is queued, then popped by the back, which registers bin results.
// Throughput: one frame beat per cycle; the front, the two-entry command queue
// and the back's output register run concurrently, limited by the output handshake.
// Reset (i_rst_n low, synchronous): T=0, B=1024, channels=2, counters cleared,
// queue and output emptied.
module pcm_minmax_envelope_binner_core import pmeb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pmeb_in_if.sink     i_frame,
    pmeb_cfg_if.sink    i_cfg,
    pmeb_out_if.source  o_bin
);

    logic     w_push;
    logic     w_full;
    logic     w_pop;
    logic     w_q_valid;
    logic     w_restart;
    t_bin_cmd w_push_cmd;
    t_bin_cmd w_pop_cmd;

    pmeb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_frame   (i_frame),
        .i_cfg     (i_cfg),
        .i_q_full  (w_full),
        .o_q_push  (w_push),
        .o_q_cmd   (w_push_cmd),
        .o_restart (w_restart)
    );

    pmeb_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_pop_cmd)
    );

    pmeb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_pop_cmd),
        .o_q_pop   (w_pop),
        .i_restart (w_restart),
        .o_bin     (o_bin)
    );

endmodule

// ===== hdl/pmeb_checker.sv =====
`include "pcm_minmax_envelope_binner_core_defines.svh"

module pmeb_checker import pmeb_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [BIN_IDX_W-1:0]    i_bin_number,
    input logic signed [SUM_W-1:0] i_bin_low,
    input logic signed [SUM_W-1:0] i_bin_high,
    input logic                    i_config_error
);

    `PMEB_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_bin_number) && $stable(i_bin_low) &&
        $stable(i_bin_high) && $stable(i_config_error),
        "result beat changed while stalled")
    `PMEB_ASSERT_IMPL(a_err_zero, i_out_valid && i_config_error,
        i_bin_number == '0 && i_bin_low == '0 && i_bin_high == '0,
        "error beat carries nonzero fields")
    `PMEB_ASSERT_IMPL(a_low_le_high, i_out_valid && !i_config_error,
        i_bin_low <= i_bin_high, "bin low above bin high")

endmodule

bind pcm_minmax_envelope_binner_core pmeb_checker u_pmeb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_bin.valid),
    .i_out_ready    (o_bin.ready),
    .i_bin_number   (o_bin.bin_number),
    .i_bin_low      (o_bin.bin_low),
    .i_bin_high     (o_bin.bin_high),
    .i_config_error (o_bin.config_error)
);
